/* rtl/pemn_pkg.sv */
// ---------------------------------------------------------------------------
// pemn_pkg
// Shared types, character codes and parse mode codes for the PEM text
// normalizer.
// ---------------------------------------------------------------------------
package pemn_pkg;

	// Character codes
	localparam logic [7:0] ChDash  = 8'h2D;
	localparam logic [7:0] ChLf    = 8'h0A;
	localparam logic [7:0] ChCr    = 8'h0D;
	localparam logic [7:0] ChSpace = 8'h20;

	// Parse modes
	localparam logic [1:0] ModeBefore = 2'd0;
	localparam logic [1:0] ModeDash   = 2'd1;
	localparam logic [1:0] ModeLabel  = 2'd2;
	localparam logic [1:0] ModeBody   = 2'd3;

	// Most data bytes one item can produce (five dashes and a newline)
	localparam int unsigned MaxBytes = 6;
	localparam logic [7:0] LineLenReset = 8'd64;

	// Group of results caused by one item
	typedef struct packed {
		logic [MaxBytes-1:0][7:0] data;
		logic [2:0]               cnt;
		logic                     fin;
	} grp_t;

	// Base64 alphabet, including the pad character
	function automatic logic is_b64(input logic [7:0] c);
		is_b64 = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
		         (c >= 8'h61 && c <= 8'h7A) || c == 8'h2B || c == 8'h2F ||
		         c == 8'h3D;
	endfunction

endpackage

/* rtl/pem_text_normalizer.sv */
// ---------------------------------------------------------------------------
// pem_text_normalizer
// Streaming cleaner for PEM armored text: collapses spaces, rewrites dash
// runs as five dashes, keeps labels and rewraps the base64 body.
// ---------------------------------------------------------------------------
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+----------------------------
//  in       | input     | in_valid / in_ready     | in_byte, in_last
//  out      | output    | out_valid / out_ready   | out_byte, has_byte,
//           |           |                         | last_of_run, stream_end
//  cfg      | input     | cfg_wr_en (no wait)     | cfg_wr_data (line_length)
//
//  An accepted item is registered in the input stage and processed there
//  against one byte of lookahead; its 0 to 7 results go into a two-entry
//  group queue. The output side sends one result per cycle while out_ready
//  is high, so an item with a single result sustains one item per cycle,
//  and an item with n results holds the output port until all n are sent.
//  Input stalls only when both group entries are full. After reset the line
//  length is 64 and the parser waits for the first byte of a text.
//
module pem_text_normalizer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       has_byte,
	output logic       last_of_run,
	output logic       stream_end
);
	import pemn_pkg::*;

	logic [7:0] line_len_q;

	// Input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Parser state
	logic [1:0] mode_q;
	logic [1:0] sec_q;
	logic [7:0] fill_q;
	logic [7:0] held_q;
	logic       held_v_q;
	logic       wn_q;

	logic [1:0] mode_d;
	logic [1:0] sec_d;
	logic [7:0] fill_d;
	logic [7:0] held_d;
	logic       held_v_d;
	logic       wn_d;

	// Group queue
	grp_t       head_q;
	grp_t       tail_q;
	logic       head_v_q;
	logic       tail_v_q;
	logic [2:0] pos_q;

	grp_t       grp;
	logic       merge;
	logic       proc;
	logic       dash_end;
	logic [1:0] sec_inc;
	logic [7:0] fill_inc;
	logic       body_put;
	logic       body_wrap;
	logic       wn_after;
	logic       closing;
	logic       grp_some;
	logic       consume;
	logic       push;
	logic       pop;
	logic       head_free;
	logic [2:0] total_m1;
	logic       at_last;

	function automatic logic [2:0] grp_total_m1(input grp_t g);
		grp_total_m1 = g.cnt + {2'b00, g.fin} - 3'd1;
	endfunction

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_len_q <= LineLenReset;
		end else if (cfg_wr_en) begin
			line_len_q <= cfg_wr_data;
		end
	end

	// Accept into the input stage whenever it is empty or drains this cycle
	assign grp_some = (grp.cnt != 3'd0) || grp.fin;
	assign consume  = valid_s1 && (!grp_some || !tail_v_q);
	assign in_ready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	// Process the held byte with the staged byte as lookahead
	assign merge     = held_v_q && held_q == ChSpace && byte_s1 == ChSpace;
	assign proc      = valid_s1 && held_v_q && !merge;
	assign dash_end  = is_b64(byte_s1) || byte_s1 == ChCr || byte_s1 == ChLf;
	assign sec_inc   = sec_q + 2'd1;
	assign fill_inc  = fill_q + 8'd1;
	assign body_put  = is_b64(held_q);
	assign body_wrap = body_put && fill_inc == line_len_q;
	assign wn_after  = body_put ? body_wrap : wn_q;
	assign closing   = byte_s1 == ChDash && !wn_after;

	always_comb begin
		grp      = '0;
		mode_d   = mode_q;
		sec_d    = sec_q;
		fill_d   = fill_q;
		wn_d     = wn_q;
		held_d   = held_q;
		held_v_d = held_v_q;
		if (proc) begin
			unique case (mode_q)
				ModeBefore: begin
					if (held_q == ChDash) begin
						grp.data[0] = ChDash;
						grp.data[1] = ChDash;
						grp.data[2] = ChDash;
						grp.data[3] = ChDash;
						grp.data[4] = ChDash;
						grp.cnt     = 3'd5;
						sec_d       = sec_inc;
						mode_d      = ModeDash;
						wn_d        = 1'b0;
						if (dash_end) begin
							if (sec_inc[0]) begin
								mode_d = ModeLabel;
							end else begin
								grp.data[5] = ChLf;
								grp.cnt     = 3'd6;
								wn_d        = 1'b1;
								mode_d      = (sec_inc == 2'd0) ? ModeBefore : ModeBody;
							end
						end
					end
				end
				ModeDash: begin
					if (dash_end) begin
						if (sec_q[0]) begin
							mode_d = ModeLabel;
						end else begin
							grp.data[0] = ChLf;
							grp.cnt     = 3'd1;
							wn_d        = 1'b1;
							mode_d      = (sec_q == 2'd0) ? ModeBefore : ModeBody;
						end
					end
				end
				ModeLabel: begin
					if (is_b64(held_q) || held_q == ChSpace) begin
						grp.data[0] = held_q;
						grp.cnt     = 3'd1;
						wn_d        = 1'b0;
					end
					if (byte_s1 == ChDash) begin
						mode_d = ModeBefore;
					end
				end
				ModeBody: begin
					// Body char, wrap newline, closing newline before a dash run
					grp.data[0] = body_put ? held_q : ChLf;
					grp.data[1] = ChLf;
					grp.cnt     = {2'b00, body_put} + {2'b00, body_wrap} + {2'b00, closing};
					wn_d        = closing ? 1'b1 : wn_after;
					if (byte_s1 == ChDash) begin
						fill_d = 8'd0;
						mode_d = ModeBefore;
					end else if (body_wrap) begin
						fill_d = 8'd0;
					end else if (body_put) begin
						fill_d = fill_inc;
					end
				end
				default: begin
					mode_d = ModeBefore;
				end
			endcase
		end
		// End of text: add the marker and start over; else hold the new byte
		if (valid_s1 && last_s1) begin
			grp.fin  = 1'b1;
			mode_d   = ModeBefore;
			sec_d    = 2'd0;
			fill_d   = 8'd0;
			wn_d     = 1'b0;
			held_d   = 8'd0;
			held_v_d = 1'b0;
		end else if (valid_s1 && !merge) begin
			held_d   = byte_s1;
			held_v_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= ModeBefore;
			sec_q    <= 2'd0;
			fill_q   <= 8'd0;
			held_q   <= 8'd0;
			held_v_q <= 1'b0;
			wn_q     <= 1'b0;
		end else if (consume) begin
			mode_q   <= mode_d;
			sec_q    <= sec_d;
			fill_q   <= fill_d;
			held_q   <= held_d;
			held_v_q <= held_v_d;
			wn_q     <= wn_d;
		end
	end

	// Output side: walk the head group one result per cycle while out_ready is high
	assign total_m1    = grp_total_m1(head_q);
	assign at_last     = pos_q == total_m1;
	assign out_valid   = head_v_q;
	assign has_byte    = pos_q < head_q.cnt;
	assign out_byte    = has_byte ? head_q.data[pos_q] : 8'd0;
	assign last_of_run = at_last;
	assign stream_end  = !has_byte && head_q.fin;

	assign pop       = head_v_q && out_ready && at_last;
	assign push      = consume && grp_some;
	assign head_free = !head_v_q || pop;

	// Advance the group queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			tail_v_q <= 1'b0;
			pos_q    <= 3'd0;
		end else begin
			if (head_v_q && out_ready) begin
				pos_q <= at_last ? 3'd0 : pos_q + 3'd1;
			end
			if (head_free) begin
				head_v_q <= tail_v_q || push;
				tail_v_q <= tail_v_q && push;
			end else if (push) begin
				tail_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (head_free) begin
			if (tail_v_q) begin
				head_q <= tail_q;
				if (push) begin
					tail_q <= grp;
				end
			end else if (push) begin
				head_q <= grp;
			end
		end else if (push) begin
			tail_q <= grp;
		end
	end

	// Checks
	a_marker_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !has_byte) |-> (stream_end && last_of_run))
		else $error("end marker not a lone final result");

	a_tail_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		tail_v_q |-> head_v_q)
		else $error("group queue tail valid without head");

	a_pos_in_group: assert property (@(posedge clk) disable iff (!arst_n)
		head_v_q |-> (pos_q <= total_m1))
		else $error("result index beyond group");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(tail_v_q && !pop) |-> !push)
		else $error("group pushed into a full queue");

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking regression for pem_text_normalizer.
// Feeds PEM-like texts (well-formed armor with random labels and bodies, plus
// broken and noisy texts) byte by byte through the input channel. A
// behavioral model predicts every cleaned byte and end marker, and the output
// side checks them in order. Runs cover several line lengths, random idling
// on both sides, and a long output hold-off that stalls the input.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pemn_pkg::*;

	localparam int unsigned CycleLimit   = 600000;
	localparam int unsigned SettleCycles = 8;
	localparam int unsigned HoldCycles   = 200;
	localparam int unsigned DashRunLen   = 5;

	typedef struct packed {
		logic [7:0] data;
		logic       data_flag;
		logic       run_last;
		logic       text_last;
	} clean_out_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [7:0] cfg_wr_data;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] in_byte;
	logic       in_last;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic       has_byte;
	logic       last_of_run;
	logic       stream_end;

	logic       hold_active = 1'b0;

	// Expected output items, oldest first
	clean_out_t expected_out[$];
	// Bytes produced by the item under prediction
	logic [7:0] step_bytes[$];
	// Text under construction
	logic [7:0] text_q[$];

	// Normalizer model state
	logic [7:0] p_line_len;
	logic [1:0] p_mode;
	logic [1:0] p_sections;
	logic [7:0] p_fill;
	logic [7:0] p_held;
	logic       p_held_v;
	logic       p_nl;

	int unsigned send_idle_pct = 0;
	int unsigned stall_pct     = 0;
	int unsigned item_cnt      = 0;
	int unsigned result_cnt    = 0;
	int unsigned text_cnt      = 0;
	int unsigned fail_cnt      = 0;
	int unsigned cycle_cnt     = 0;

	pem_text_normalizer i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.in_last    (in_last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.has_byte   (has_byte),
		.last_of_run(last_of_run),
		.stream_end (stream_end)
	);

	// 50 MHz clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CycleLimit) begin
			$display("pem_text_normalizer regression: fail");
			$finish;
		end
	end

	// Drive output ready: random stalls, or a long hold-off when requested
	always @(posedge clk) begin
		if (hold_active)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Compare each output item against the oldest expectation
	always @(posedge clk) begin : check_results
		clean_out_t want;
		if (arst_n && out_valid && out_ready) begin
			result_cnt++;
			if (expected_out.size() == 0) begin
				$error("unexpected item: out_byte %0h has_byte %0b stream_end %0b",
					out_byte, has_byte, stream_end);
				fail_cnt++;
			end else begin
				want = expected_out.pop_front();
				if (out_byte !== want.data) begin
					$error("out_byte: expected %0h, got %0h", want.data, out_byte);
					fail_cnt++;
				end
				if (has_byte !== want.data_flag) begin
					$error("has_byte: expected %0b, got %0b", want.data_flag, has_byte);
					fail_cnt++;
				end
				if (last_of_run !== want.run_last) begin
					$error("last_of_run: expected %0b, got %0b", want.run_last, last_of_run);
					fail_cnt++;
				end
				if (stream_end !== want.text_last) begin
					$error("stream_end: expected %0b, got %0b", want.text_last, stream_end);
					fail_cnt++;
				end
			end
		end
	end

	function automatic bit is_base64(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
		       (c >= "a" && c <= "z") || c == "+" || c == "/" || c == "=";
	endfunction

	function automatic logic [7:0] rand_b64();
		int unsigned k;
		k = $urandom_range(0, 64);
		if (k < 10)
			return 8'(32'h30 + k);
		if (k < 36)
			return 8'(32'h41 + k - 10);
		if (k < 62)
			return 8'(32'h61 + k - 36);
		if (k == 62)
			return "+";
		if (k == 63)
			return "/";
		return "=";
	endfunction

	// Return the model to the start of a text; line length is kept
	task automatic clear_text_state();
		p_mode     = ModeBefore;
		p_sections = 2'd0;
		p_fill     = 8'd0;
		p_held     = 8'd0;
		p_held_v   = 1'b0;
		p_nl       = 1'b0;
	endtask

	// Emit one cleaned byte; at most one dash run plus a newline per item
	task automatic put_byte(input logic [7:0] c);
		if (step_bytes.size() < MaxBytes)
			step_bytes.push_back(c);
		p_nl = (c == ChLf);
	endtask

	// Close a dash run on the first lookahead that is base64, CR or LF
	task automatic leave_dash(input logic [7:0] nxt);
		if (is_base64(nxt) || nxt == ChCr || nxt == ChLf) begin
			case (p_sections)
				2'd1, 2'd3: p_mode = ModeLabel;
				2'd0: begin
					put_byte(ChLf);
					p_mode = ModeBefore;
				end
				default: begin
					put_byte(ChLf);
					p_mode = ModeBody;
				end
			endcase
		end
	endtask

	// Process the held byte against its lookahead
	task automatic consume_held(input logic [7:0] cur, input logic [7:0] nxt);
		case (p_mode)
			ModeBefore: begin
				if (cur == ChDash) begin
					repeat (DashRunLen) put_byte(ChDash);
					p_sections = p_sections + 2'd1;
					p_mode     = ModeDash;
					leave_dash(nxt);
				end
			end
			ModeDash: leave_dash(nxt);
			ModeLabel: begin
				if (is_base64(cur) || cur == ChSpace)
					put_byte(cur);
				if (nxt == ChDash)
					p_mode = ModeBefore;
			end
			default: begin
				if (is_base64(cur)) begin
					put_byte(cur);
					p_fill = p_fill + 8'd1;
					if (p_fill == p_line_len) begin
						put_byte(ChLf);
						p_fill = 8'd0;
					end
				end
				if (nxt == ChDash) begin
					if (!p_nl)
						put_byte(ChLf);
					p_fill = 8'd0;
					p_mode = ModeBefore;
				end
			end
		endcase
	endtask

	// Predict the output items caused by one accepted input item
	task automatic predict_item(input logic [7:0] b, input logic last);
		bit         merge;
		clean_out_t grp[$];
		step_bytes = {};
		merge = p_held_v && p_held == ChSpace && b == ChSpace;
		if (p_held_v && !merge)
			consume_held(p_held, b);
		foreach (step_bytes[k])
			grp.push_back('{step_bytes[k], 1'b1, 1'b0, 1'b0});
		if (last) begin
			grp.push_back('{8'h00, 1'b0, 1'b0, 1'b1});
			clear_text_state();
		end else if (!merge) begin
			p_held   = b;
			p_held_v = 1'b1;
		end
		if (grp.size() > 0)
			grp[grp.size() - 1].run_last = 1'b1;
		foreach (grp[k])
			expected_out.push_back(grp[k]);
	endtask

	// Offer one item, hold it until accepted, then predict its results
	task automatic send_item(input logic [7:0] b, input logic last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		in_last  <= last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_item(b, last);
		item_cnt++;
	endtask

	// Send the built text; mark the final byte only when closing the text
	task automatic send_text(input bit close);
		for (int k = 0; k < text_q.size(); k++)
			send_item(text_q[k], close && (k == text_q.size() - 1));
		if (close)
			text_cnt++;
	endtask

	// Drop valid, wait for all expected items, then let the pipeline go quiet
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_out.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic set_line_len(input logic [7:0] len);
		settle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= len;
		@(posedge clk);
		cfg_wr_en  <= 1'b0;
		p_line_len = len;
	endtask

	task automatic push_str(input string s);
		for (int k = 0; k < s.len(); k++)
			text_q.push_back(s[k]);
	endtask

	task automatic add_dash_run();
		int unsigned n;
		n = ($urandom_range(0, 99) < 75) ? DashRunLen : $urandom_range(1, 9);
		repeat (n) text_q.push_back(ChDash);
	endtask

	task automatic add_spaces(input int unsigned most);
		repeat ($urandom_range(0, most)) text_q.push_back(ChSpace);
	endtask

	// Label words separated by space runs
	task automatic add_label();
		int unsigned words;
		words = $urandom_range(1, 3);
		for (int w = 0; w < words; w++) begin
			repeat ($urandom_range(1, 6)) text_q.push_back(rand_b64());
			if (w < words - 1)
				repeat ($urandom_range(1, 3)) text_q.push_back(ChSpace);
		end
	endtask

	// Mostly base64 with stray line breaks, spaces and arbitrary bytes
	task automatic add_body(input int unsigned n);
		int unsigned r;
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 85)
				text_q.push_back(rand_b64());
			else if (r < 90)
				text_q.push_back(ChLf);
			else if (r < 94)
				text_q.push_back(ChSpace);
			else if (r < 97)
				text_q.push_back(ChCr);
			else
				text_q.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic add_armor_line();
		add_dash_run();
		add_spaces(2);
		add_label();
		add_spaces(2);
		add_dash_run();
		add_spaces(1);
		if ($urandom_range(0, 1))
			text_q.push_back(ChCr);
		text_q.push_back(ChLf);
	endtask

	// Build one text: armored blocks, a noise burst, or a truncated block
	task automatic build_text(input bit well_formed);
		int unsigned kind;
		int unsigned n;
		text_q = {};
		kind = well_formed ? 99 : $urandom_range(0, 99);
		if (kind < 12) begin
			repeat ($urandom_range(1, 12)) begin
				n = $urandom_range(0, 99);
				if (n < 30)
					text_q.push_back(ChDash);
				else if (n < 50)
					text_q.push_back(ChSpace);
				else
					text_q.push_back(8'($urandom_range(0, 255)));
			end
		end else begin
			if ($urandom_range(0, 9) == 0)
				add_body(3);
			repeat (($urandom_range(0, 99) < 70) ? 1 : $urandom_range(2, 3)) begin
				add_armor_line();
				add_body($urandom_range(0, 30));
				if ($urandom_range(0, 1))
					text_q.push_back(ChLf);
				add_armor_line();
			end
			text_q.push_back(8'($urandom_range(0, 255)));
			if (kind < 25) begin
				n = $urandom_range(1, text_q.size());
				text_q = text_q[0:n-1];
			end
		end
	endtask

	// Single-byte text, a trailing space run, and the byte extremes
	task automatic test_short_texts();
		text_q = {ChDash};
		send_text(1'b1);
		text_q = {ChSpace, ChSpace};
		send_text(1'b1);
		text_q = {8'h00, 8'hFF};
		send_text(1'b1);
	endtask

	// Label with a space run, CR/LF after a run, body wrap, all four counts
	task automatic test_sections();
		set_line_len(8'd2);
		text_q = {};
		push_str("-L  -");
		text_q.push_back(ChCr);
		text_q.push_back(ChLf);
		push_str("AB-E-");
		text_q.push_back(ChLf);
		push_str("-");
		send_text(1'b1);
	endtask

	// Longest line, then shrink below the current fill so the count wraps
	task automatic test_line_wrap();
		set_line_len(8'd255);
		text_q = {};
		push_str("-A--");
		text_q.push_back(ChLf);
		repeat (254) text_q.push_back(rand_b64());
		send_text(1'b0);
		set_line_len(8'd1);
		text_q = {};
		repeat (4) text_q.push_back(rand_b64());
		push_str("-x");
		send_text(1'b1);
	endtask

	task automatic run_phase(input int unsigned idle, input int unsigned stall,
		input logic [7:0] len, input int unsigned n);
		int unsigned start;
		set_line_len(len);
		send_idle_pct = idle;
		stall_pct     = stall;
		start = item_cnt;
		while (item_cnt - start < n) begin
			build_text(1'b0);
			send_text(1'b1);
		end
	endtask

	// Random texts under each idling mix
	task automatic test_idle_mixes();
		run_phase(0, 0, 8'd5, 15);
		run_phase(79, 0, 8'd1, 15);
		run_phase(0, 79, 8'd13, 15);
		run_phase(33, 33, 8'd64, 15);
	endtask

	// Hold the output off while the sender keeps offering items
	task automatic test_output_hold();
		set_line_len(8'd3);
		send_idle_pct = 0;
		stall_pct     = 0;
		fork
			begin
				hold_active <= 1'b1;
				repeat (HoldCycles) @(posedge clk);
				hold_active <= 1'b0;
			end
		join_none
		build_text(1'b1);
		send_text(1'b1);
	endtask

	initial begin
		arst_n      <= 1'b0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= 8'd0;
		in_valid    <= 1'b0;
		in_byte     <= 8'd0;
		in_last     <= 1'b0;
		p_line_len  = LineLenReset;
		clear_text_state();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_short_texts();
		test_sections();
		test_line_wrap();
		test_idle_mixes();
		test_output_hold();
		settle();

		$display("Covered %0d texts: %0d input items checked against %0d output items.",
			text_cnt, item_cnt, result_cnt);
		$display("Line lengths 1 to 255, four idle mixes and one long output hold-off.");
		if (fail_cnt == 0)
			$display("pem_text_normalizer regression: pass");
		else
			$display("pem_text_normalizer regression: fail");
		$finish;
	end

endmodule

/* files.f */
rtl/pemn_pkg.sv
rtl/pem_text_normalizer.sv
bench/tb.sv
